FILE: rtl/pgi_pkg.sv
`default_nettype none
package pgi_pkg;

  localparam int PALETTE_ENTRIES_DEF = 7;
  localparam int MAX_ENTRIES = 8;
  localparam int REG_COUNT = 7;
  localparam int CFG_IDX_W = 3;
  localparam int ENTRY_W = 33;
  localparam int BP_W = 9;
  localparam int CH_W = 8;
  localparam int NUM_W = 17;
  localparam int STEP_BITS = 2;
  localparam int DIV_STAGES = CH_W / STEP_BITS;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [BP_W-1:0] bp_t;
  typedef logic [2:0][CH_W-1:0] rgb_t;
  typedef logic [2:0][NUM_W-1:0] num_t;

  localparam entry_t RESET_TABLE [MAX_ENTRIES] = '{
    33'h000000000, 33'h01EFF0000, 33'h04600FF00, 33'h06E0000FF,
    33'h096FF00FF, 33'h0FFFFFFFF, 33'h100000000, 33'h000000000
  };

  function automatic bp_t bp_of(input entry_t e);
    return e[32:24];
  endfunction

  // Channel 0 is red, 1 green, 2 blue.
  function automatic rgb_t color_of(input entry_t e);
    rgb_t c;
    c[0] = e[23:16];
    c[1] = e[15:8];
    c[2] = e[7:0];
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pgi_if.sv
`default_nettype none
interface pgi_count_if import pgi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BP_W-1:0] iteration_count;
  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

interface pgi_color_if import pgi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_level;
  logic [CH_W-1:0] green_level;
  logic [CH_W-1:0] blue_level;
  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

interface pgi_cfg_if import pgi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ENTRY_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/palette_gradient_interpolator_top.sv
`default_nettype none
// Throughput: one beat per cycle unless color.ready stalls the pipeline; the
// restoring divider is cut into four stages of two quotient bits each, after
// segment select, mux and multiply.
// Reset (rst, synchronous) empties the pipeline and loads the default gradient.
module palette_gradient_interpolator_top import pgi_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  pgi_count_if.sink   pixel,
  pgi_color_if.source color,
  pgi_cfg_if.sink     cfg
);

  localparam int SEL_W = PALETTE_ENTRIES - 1;
  localparam int NSTG = 3 + DIV_STAGES;

  entry_t palette [PALETTE_ENTRIES];

  logic [NSTG-1:0] v;
  logic [NSTG:0]   adv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      if (rst) begin
        palette[k] <= RESET_TABLE[k];
      end else if (cfg.valid && cfg.index == CFG_IDX_W'(k) && k < REG_COUNT) begin
        palette[k] <= cfg.data;
      end
    end
  end

  // Each stage loads when it is empty or its successor moves on.
  always_comb begin
    adv[NSTG] = color.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign pixel.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= pixel.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: segment select by parallel compares.
  logic [SEL_W-1:0] sel_next;
  logic             below_next;
  logic [SEL_W-1:0] s0_sel;
  logic             s0_below;
  bp_t              s0_count;

  always_comb begin
    logic seen;
    seen = 1'b0;
    below_next = pixel.iteration_count < bp_of(palette[0]);
    for (int k = 0; k < SEL_W; k++) begin
      sel_next[k] = !seen && (pixel.iteration_count <= bp_of(palette[k+1]));
      seen = seen || (pixel.iteration_count <= bp_of(palette[k+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_sel <= sel_next;
      s0_below <= below_next;
      s0_count <= pixel.iteration_count;
    end
  end

  // Stage 1: pick the segment ends and form width and offset.
  rgb_t c1_next, c2_next;
  bp_t  w_next, d_next;
  rgb_t s1_c1, s1_c2;
  bp_t  s1_w, s1_d;

  always_comb begin
    bp_t lo, hi, w_raw;
    lo = '0;
    hi = '0;
    c1_next = '0;
    c2_next = '0;
    for (int k = 0; k < SEL_W; k++) begin
      if (s0_sel[k]) begin
        lo = lo | bp_of(palette[k]);
        hi = hi | bp_of(palette[k+1]);
        c1_next = c1_next | color_of(palette[k]);
        c2_next = c2_next | color_of(palette[k+1]);
      end
    end
    w_raw = hi - lo;
    w_next = w_raw;
    d_next = s0_count - lo;
    if (s0_below) begin
      c1_next = color_of(palette[0]);
      c2_next = c1_next;
      w_next = BP_W'(1);
      d_next = '0;
    end else if (s0_sel == '0) begin
      c1_next = '0;
      c2_next = '0;
      w_next = BP_W'(1);
      d_next = '0;
    end else if (w_raw == '0) begin
      c2_next = c1_next;
      w_next = BP_W'(1);
      d_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_c1 <= c1_next;
      s1_c2 <= c2_next;
      s1_w <= w_next;
      s1_d <= d_next;
    end
  end

  // Stage 2: numerators c1*(w-d) + c2*d.
  num_t num_next;
  num_t dv_rem [DIV_STAGES+1];
  rgb_t dv_q [DIV_STAGES+1];
  bp_t  dv_w [DIV_STAGES+1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_next[j] = NUM_W'(s1_c1[j]) * NUM_W'(s1_w - s1_d)
                  + NUM_W'(s1_c2[j]) * NUM_W'(s1_d);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dv_rem[0] <= num_next;
      dv_q[0] <= '0;
      dv_w[0] <= s1_w;
    end
  end

  // Stages 3 and up: restoring division, two quotient bits per stage.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    num_t rem_o;
    logic [2:0][STEP_BITS-1:0] q_o;

    for (genvar j = 0; j < 3; j++) begin : g_ch
      pgi_div_step #(
        .HI_BIT(CH_W - 1 - STEP_BITS * s)
      ) u_step (
        .rem_i(dv_rem[s][j]),
        .w    (dv_w[s]),
        .rem_o(rem_o[j]),
        .q_o  (q_o[j])
      );
    end

    always_ff @(posedge clk) begin
      if (adv[3+s]) begin
        dv_rem[s+1] <= rem_o;
        dv_w[s+1] <= dv_w[s];
        for (int j = 0; j < 3; j++) begin
          dv_q[s+1][j] <= {dv_q[s][j][CH_W-STEP_BITS-1:0], q_o[j]};
        end
      end
    end
  end

  assign color.valid = v[NSTG-1];
  assign color.red_level = dv_q[DIV_STAGES][0];
  assign color.green_level = dv_q[DIV_STAGES][1];
  assign color.blue_level = dv_q[DIV_STAGES][2];

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> $onehot0(s0_sel))
    else $error("segment select is not one-hot");

  a_num_range: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (dv_rem[0][0][NUM_W-1:CH_W] < dv_w[0] && dv_rem[0][1][NUM_W-1:CH_W] < dv_w[0]
              && dv_rem[0][2][NUM_W-1:CH_W] < dv_w[0]))
    else $error("numerator overflows the quotient width");

  a_rem_final: assert property (@(posedge clk) disable iff (rst)
    v[NSTG-1] |-> (dv_rem[DIV_STAGES][0] < NUM_W'(dv_w[DIV_STAGES])
                   && dv_rem[DIV_STAGES][1] < NUM_W'(dv_w[DIV_STAGES])
                   && dv_rem[DIV_STAGES][2] < NUM_W'(dv_w[DIV_STAGES])))
    else $error("division remainder not below divisor");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (color.valid && !color.ready))
    else $error("input stalled while output is free");

endmodule
`default_nettype wire

FILE: rtl/pgi_div_step.sv
`default_nettype none
module pgi_div_step import pgi_pkg::*; #(
  parameter int HI_BIT = 7
) (
  input  wire logic [NUM_W-1:0]     rem_i,
  input  wire logic [BP_W-1:0]      w,
  output logic      [NUM_W-1:0]     rem_o,
  output logic      [STEP_BITS-1:0] q_o
);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsub;

  always_comb begin
    rem = rem_i;
    dsub = '0;
    q_o = '0;
    for (int b = 0; b < STEP_BITS; b++) begin
      dsub = NUM_W'(w) << (HI_BIT - b);
      if (rem >= dsub) begin
        rem = rem - dsub;
        q_o[STEP_BITS-1-b] = 1'b1;
      end
    end
    rem_o = rem;
  end

endmodule
`default_nettype wire

FILE: tb/pgi_gradient_checker.sv
`timescale 1ns / 1ps
module pgi_gradient_checker import pgi_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  pgi_count_if     pixel,
  pgi_color_if     color,
  pgi_cfg_if       cfg,
  output int       errors,
  output int       outstanding
);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  entry_t palette [PALETTE_ENTRIES_DEF];
  color_t expected_colors [$];

  function automatic int unsigned breakpoint(input entry_t e);
    return int'(e[32:24]);
  endfunction

  function automatic color_t gradient_color(input bp_t count);
    int unsigned lo;
    int unsigned hi;
    int unsigned w;
    int unsigned d;
    int unsigned c1;
    int unsigned c2;
    logic [23:0] rgb;
    if (count < breakpoint(palette[0])) begin
      return color_t'(palette[0][23:0]);
    end
    for (int k = 0; k + 1 < PALETTE_ENTRIES_DEF; k++) begin
      hi = breakpoint(palette[k+1]);
      if (count <= hi) begin
        lo = breakpoint(palette[k]);
        w = hi - lo;
        d = count - lo;
        if (w == 0) begin
          return color_t'(palette[k][23:0]);
        end
        for (int ch = 0; ch < 3; ch++) begin
          c1 = 32'(palette[k][23-8*ch -: 8]);
          c2 = 32'(palette[k+1][23-8*ch -: 8]);
          rgb[23-8*ch -: 8] = 8'((c1 * (w - d) + c2 * d) / w);
        end
        return color_t'(rgb);
      end
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    color_t got;
    color_t want;
    if (rst) begin
      for (int k = 0; k < PALETTE_ENTRIES_DEF; k++) begin
        palette[k] = RESET_TABLE[k];
      end
      expected_colors.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < REG_COUNT && cfg.index < PALETTE_ENTRIES_DEF) begin
        palette[cfg.index] = cfg.data;
      end
      if (color.valid && color.ready) begin
        got = {color.red_level, color.green_level, color.blue_level};
        if (expected_colors.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("color beat with none expected: r=%0d g=%0d b=%0d",
                     got.red, got.green, got.blue);
          end
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            errors++;
            if (errors <= 10) begin
              $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
          end
        end
      end
      if (pixel.valid && pixel.ready) begin
        expected_colors.push_back(gradient_color(pixel.iteration_count));
      end
    end
    outstanding <= expected_colors.size();
  end

endmodule

FILE: tb/tb_palette_gradient_interpolator_top.sv
`timescale 1ns / 1ps
module tb_palette_gradient_interpolator_top;
  import pgi_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PIPE_LATENCY = 7;
  localparam int PHASE_BEATS = 100;

  typedef enum int {
    PAL_RESET, PAL_ZERO, PAL_ONES, PAL_FLAT_FIRST, PAL_SCRAMBLED, PAL_RISING
  } palette_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int          cycles = 0;
  int          errors;
  int          outstanding;
  entry_t      palette_shadow [REG_COUNT];

  pgi_count_if pixel ();
  pgi_color_if color ();
  pgi_cfg_if   cfg ();

  palette_gradient_interpolator_top u_top (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .color (color),
    .cfg   (cfg)
  );

  pgi_gradient_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .color       (color),
    .cfg         (cfg),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    color.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("palette_gradient_interpolator_top regression: fail");
      $finish;
    end
  end

  task automatic send_count(input bp_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.iteration_count <= value;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input entry_t value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx < REG_COUNT) begin
      palette_shadow[idx] = value;
    end
  endtask

  function automatic logic [23:0] random_rgb();
    logic [23:0] rgb;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(3))
        0: rgb[8*ch +: 8] = 8'h00;
        1: rgb[8*ch +: 8] = 8'hFF;
        default: rgb[8*ch +: 8] = 8'($urandom_range(255));
      endcase
    end
    return rgb;
  endfunction

  task automatic load_palette(input palette_kind_e kind);
    entry_t vals [REG_COUNT];
    int     bp;
    bp = $urandom_range(60);
    for (int k = 0; k < REG_COUNT; k++) begin
      case (kind)
        PAL_RESET: vals[k] = RESET_TABLE[k];
        PAL_ZERO: vals[k] = '0;
        PAL_ONES: vals[k] = '1;
        PAL_SCRAMBLED: vals[k] = {1'($urandom_range(1)), 32'($urandom())};
        default: begin
          vals[k] = {9'(bp), random_rgb()};
          bp += $urandom_range(1, 90);
          if (bp > 511) begin
            bp = 511;
          end
        end
      endcase
    end
    // Both lower entries share one breakpoint, so the first segment has no width.
    if (kind == PAL_FLAT_FIRST) begin
      vals[1][32:24] = vals[0][32:24];
    end
    write_reg(3'(REG_COUNT), {1'($urandom_range(1)), 32'($urandom())});
    for (int k = 0; k < REG_COUNT; k++) begin
      write_reg(3'(k), vals[k]);
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic bp_t pick_count();
    int c;
    if ($urandom_range(9) < 4) begin
      return bp_t'($urandom_range(511));
    end
    c = int'(palette_shadow[$urandom_range(REG_COUNT - 1)][32:24]) + $urandom_range(6) - 3;
    if (c < 0) begin
      c = 0;
    end else if (c > 511) begin
      c = 511;
    end
    return bp_t'(c);
  endfunction

  initial begin
    bp_t           directed_counts [21];
    palette_kind_e kind;
    pixel.valid = 1'b0;
    pixel.iteration_count = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    color.ready = 1'b0;
    tx_idle_pct = 32;
    rx_idle_pct = 48;
    for (int k = 0; k < REG_COUNT; k++) begin
      palette_shadow[k] = RESET_TABLE[k];
    end
    directed_counts = '{0, 1, 15, 29, 30, 31, 50, 69, 70, 109, 110, 111, 149, 150, 200,
                        254, 255, 256, 257, 300, 511};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_counts[i]) begin
      send_count(directed_counts[i]);
    end
    pixel.valid <= 1'b0;

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 6; p++) begin
        case (p)
          0: kind = (mode == 0) ? PAL_ZERO : (mode == 1) ? PAL_ONES : PAL_FLAT_FIRST;
          1: kind = PAL_SCRAMBLED;
          5: kind = (mode == 2) ? PAL_RESET : PAL_RISING;
          default: kind = PAL_RISING;
        endcase
        wait_drained();
        load_palette(kind);
        for (int i = 0; i < PHASE_BEATS; i++) begin
          send_count(pick_count());
        end
        pixel.valid <= 1'b0;
      end
    end

    wait_drained();
    repeat (PIPE_LATENCY + 3) @(posedge clk);
    if (errors == 0) begin
      $display("palette_gradient_interpolator_top regression: pass");
    end else begin
      $display("palette_gradient_interpolator_top regression: fail");
    end
    $finish;
  end

endmodule
